@@ src/assert_macros.svh @@
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
	else $error(msg);

`endif

@@ src/opp_pkg.sv @@
// Types and constants of the operator precedence parser
package opp_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int SP_W        = $clog2(STACK_DEPTH);
	localparam int SPX_W       = SP_W + 1;
	localparam int SYM_W       = 3;
	localparam int ENT_W       = 4;
	localparam int RED_W       = 6;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 64;

	localparam logic [ENT_W-1:0] MARK_ENTRY = 4'h8;
	localparam logic [RED_W-1:0] RED_MAX    = 6'd63;
	localparam logic [SYM_W-1:0] END_RESET  = 3'd7;

	typedef enum logic [1:0] {
		REL_BLANK   = 2'd0,
		REL_LESS    = 2'd1,
		REL_EQUAL   = 2'd2,
		REL_GREATER = 2'd3
	} rel_t;

	typedef enum logic [1:0] {
		ST_SHIFT  = 2'd0,
		ST_ACCEPT = 2'd1,
		ST_BLANK  = 2'd2,
		ST_FAULT  = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_REL_LO = 2'd0,
		CFG_REL_HI = 2'd1,
		CFG_END    = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_PUSH_SYM,
		S_REDUCE,
		S_FINISH
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic    load_sym;
		logic    clear;
		logic    push_mark;
		logic    push_sym;
		logic    pop;
		logic    inc_red;
		logic    set_code;
		status_t code;
		logic    emit;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_accept;
		rel_t rel;
		logic less_ovf;
		logic eq_ovf;
		logic top_is_mark;
		logic sp_zero;
	} stat_t;

endpackage

@@ src/opp_sym_if.sv @@
// Input channel: one terminal symbol per item
interface opp_sym_if;
	logic                      valid;
	logic                      ready;
	logic [opp_pkg::SYM_W-1:0] symbol;

	modport source (output valid, output symbol, input ready);
	modport sink (input valid, input symbol, output ready);
endinterface

@@ src/opp_res_if.sv @@
// Output channel: one parse result per item
interface opp_res_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                status;
	logic [opp_pkg::RED_W-1:0] reductions;

	modport source (output valid, output status, output reductions, input ready);
	modport sink (input valid, input status, input reductions, output ready);
endinterface

@@ src/opp_cfg_if.sv @@
// Configuration write channel
interface opp_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [opp_pkg::CFG_IDX_W-1:0]  index;
	logic [opp_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ src/operator_precedence_parser.sv @@
// Operator precedence parser top level: sequencer, datapath and channel hookup
// Each input item is one terminal index; exactly one result item comes back per
// input item. Each item is accepted, its relation is evaluated and its result is
// delivered; when the relation is less and both entries fit, the mark and then the
// symbol are pushed in turn through the single stack write port; when it is greater,
// the sequencer pops one stack entry per reduce step and evaluates again after every
// completed reduction, and a greater relation that finds no mark above the bottom
// entry ends in a stack fault. A new item is taken once the current
// one has reached the result register, even while that result still waits to be
// taken; a result waits in the final cycle only if the previous one is unread.
// The stack is a 64-entry memory with one write and one read port and needs no
// clearing pass after reset. Configuration writes are taken in any cycle.
`include "assert_macros.svh"

module operator_precedence_parser (
	input  logic       clk,
	input  logic       arst_n,
	opp_sym_if.sink    symbols,
	opp_res_if.source  results,
	opp_cfg_if.sink    cfg
);

	opp_pkg::cmd_t  cmd;
	opp_pkg::stat_t stat;

	opp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (symbols.valid),
		.in_ready  (symbols.ready),
		.out_ready (results.ready),
		.out_valid (results.valid),
		.stat      (stat),
		.cmd       (cmd)
	);

	opp_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg.valid),
		.cfg_ready      (cfg.ready),
		.cfg_index      (cfg.index),
		.cfg_data       (cfg.data),
		.in_symbol      (symbols.symbol),
		.out_status     (results.status),
		.out_reductions (results.reductions),
		.cmd            (cmd),
		.stat           (stat)
	);

	`ASSERT_IMP(a_pop_above_bottom, clk, arst_n, cmd.pop, !stat.sp_zero, "pop at bottom entry")
	`ASSERT_IMP(a_push_in_range, clk, arst_n, cmd.push_sym, !stat.eq_ovf, "push past stack depth")
	`ASSERT_IMP(a_emit_slot_free, clk, arst_n, cmd.emit, !results.valid || results.ready, "result overwritten before taken")
	`ASSERT_NXT(a_emit_valid, clk, arst_n, cmd.emit, results.valid, "emitted item not presented")

endmodule

@@ src/opp_ctrl.sv @@
// Parser sequencer: walks each item through evaluate, push, reduce and result
module opp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           out_ready,
	output logic           out_valid,
	input  opp_pkg::stat_t stat,
	output opp_pkg::cmd_t  cmd
);

	opp_pkg::state_t state_q, state_d;
	logic            out_valid_q;
	logic            slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= opp_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			opp_pkg::S_IDLE: begin
				if (in_valid)
					state_d = opp_pkg::S_EVAL;
			end
			opp_pkg::S_EVAL: begin
				if (stat.is_accept)
					state_d = opp_pkg::S_FINISH;
				else begin
					unique case (stat.rel)
						opp_pkg::REL_LESS:
							state_d = stat.less_ovf ? opp_pkg::S_FINISH : opp_pkg::S_PUSH_SYM;
						opp_pkg::REL_GREATER:
							state_d = opp_pkg::S_REDUCE;
						default:
							state_d = opp_pkg::S_FINISH;
					endcase
				end
			end
			opp_pkg::S_PUSH_SYM: state_d = opp_pkg::S_FINISH;
			opp_pkg::S_REDUCE: begin
				if (stat.sp_zero)
					state_d = opp_pkg::S_FINISH;
				else if (stat.top_is_mark)
					state_d = opp_pkg::S_EVAL;
			end
			opp_pkg::S_FINISH: begin
				if (slot_free)
					state_d = opp_pkg::S_IDLE;
			end
			default: state_d = opp_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.code = opp_pkg::ST_SHIFT;
		in_ready = 1'b0;
		unique case (state_q)
			opp_pkg::S_IDLE: begin
				in_ready     = 1'b1;
				cmd.load_sym = in_valid;
			end
			opp_pkg::S_EVAL: begin
				cmd.set_code = 1'b1;
				if (stat.is_accept) begin
					cmd.code  = opp_pkg::ST_ACCEPT;
					cmd.clear = 1'b1;
				end else begin
					unique case (stat.rel)
						opp_pkg::REL_BLANK: begin
							cmd.code  = opp_pkg::ST_BLANK;
							cmd.clear = 1'b1;
						end
						opp_pkg::REL_LESS: begin
							if (stat.less_ovf) begin
								cmd.code  = opp_pkg::ST_FAULT;
								cmd.clear = 1'b1;
							end else
								cmd.push_mark = 1'b1;
						end
						opp_pkg::REL_EQUAL: begin
							if (stat.eq_ovf) begin
								cmd.code  = opp_pkg::ST_FAULT;
								cmd.clear = 1'b1;
							end else
								cmd.push_sym = 1'b1;
						end
						default: cmd.set_code = 1'b0;
					endcase
				end
			end
			opp_pkg::S_PUSH_SYM: cmd.push_sym = 1'b1;
			opp_pkg::S_REDUCE: begin
				if (stat.sp_zero) begin
					// popped to the bottom without meeting a mark
					cmd.set_code = 1'b1;
					cmd.code     = opp_pkg::ST_FAULT;
					cmd.clear    = 1'b1;
				end else begin
					cmd.pop     = 1'b1;
					cmd.inc_red = stat.top_is_mark;
				end
			end
			opp_pkg::S_FINISH: cmd.emit = slot_free;
			default: ;
		endcase
	end

endmodule

@@ src/opp_datapath.sv @@
// Parser datapath: config registers, relation lookup, parse stack and result register
module opp_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [opp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [opp_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [opp_pkg::SYM_W-1:0]      in_symbol,
	output logic [1:0]                     out_status,
	output logic [opp_pkg::RED_W-1:0]      out_reductions,
	input  opp_pkg::cmd_t                  cmd,
	output opp_pkg::stat_t                 stat
);

	logic [opp_pkg::CFG_DATA_W-1:0] rel_lo_q, rel_hi_q;
	logic [opp_pkg::SYM_W-1:0]      end_q;
	logic [opp_pkg::SYM_W-1:0]      sym_q;
	logic [opp_pkg::SP_W-1:0]       sp_q;
	logic [opp_pkg::ENT_W-1:0]      top_q;
	logic [opp_pkg::RED_W-1:0]      red_q;
	opp_pkg::status_t               code_q;
	logic [1:0]                     out_status_q;
	logic [opp_pkg::RED_W-1:0]      out_red_q;

	logic [opp_pkg::ENT_W-1:0]      stack_mem [opp_pkg::STACK_DEPTH];

	logic                           sp_zero;
	logic [opp_pkg::ENT_W-1:0]      top_ent;
	logic [opp_pkg::SYM_W-1:0]      top_sym;
	logic [opp_pkg::CFG_DATA_W-1:0] rel_word;
	logic [5:0]                     rel_sel;
	logic [opp_pkg::SPX_W-1:0]      sp_ext;
	logic [opp_pkg::SP_W-1:0]       sp_up, sp_dn;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rel_lo_q <= '0;
			rel_hi_q <= '0;
			end_q    <= opp_pkg::END_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				opp_pkg::CFG_REL_LO: rel_lo_q <= cfg_data;
				opp_pkg::CFG_REL_HI: rel_hi_q <= cfg_data;
				opp_pkg::CFG_END:    end_q    <= cfg_data[opp_pkg::SYM_W-1:0];
				default: ;
			endcase
		end
	end

	// bottom entry always reads as the current end symbol
	assign sp_zero = (sp_q == '0);
	assign top_ent = sp_zero ? {1'b0, end_q} : top_q;
	assign top_sym = top_ent[opp_pkg::SYM_W-1:0];

	assign rel_word = top_sym[2] ? rel_hi_q : rel_lo_q;
	assign rel_sel  = {top_sym[1:0], sym_q, 1'b0};

	assign sp_ext = {1'b0, sp_q};
	assign sp_up  = sp_q + 1'b1;
	assign sp_dn  = sp_q - 1'b1;

	always_comb begin
		stat.is_accept   = (top_sym == end_q) && (sym_q == end_q);
		stat.rel         = opp_pkg::rel_t'(rel_word[rel_sel +: 2]);
		stat.less_ovf    = (sp_ext + opp_pkg::SPX_W'(2)) >= opp_pkg::SPX_W'(opp_pkg::STACK_DEPTH);
		stat.eq_ovf      = (sp_ext + opp_pkg::SPX_W'(1)) >= opp_pkg::SPX_W'(opp_pkg::STACK_DEPTH);
		stat.top_is_mark = (top_ent == opp_pkg::MARK_ENTRY);
		stat.sp_zero     = sp_zero;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
		end else if (cmd.clear) begin
			sp_q <= '0;
		end else if (cmd.push_mark || cmd.push_sym) begin
			sp_q <= sp_up;
		end else if (cmd.pop) begin
			sp_q <= sp_dn;
		end
	end

	// stack memory; the top entry is cached and refilled by a registered read on a pop
	always_ff @(posedge clk) begin
		if (cmd.push_mark)
			stack_mem[sp_up] <= opp_pkg::MARK_ENTRY;
		else if (cmd.push_sym)
			stack_mem[sp_up] <= {1'b0, sym_q};

		if (cmd.push_mark)
			top_q <= opp_pkg::MARK_ENTRY;
		else if (cmd.push_sym)
			top_q <= {1'b0, sym_q};
		else if (cmd.pop)
			top_q <= stack_mem[sp_dn];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_sym)
			sym_q <= in_symbol;

		if (cmd.load_sym)
			red_q <= '0;
		else if (cmd.inc_red && red_q != opp_pkg::RED_MAX)
			red_q <= red_q + 1'b1;

		if (cmd.set_code)
			code_q <= cmd.code;

		if (cmd.emit) begin
			out_status_q <= code_q;
			out_red_q    <= red_q;
		end
	end

	assign out_status     = out_status_q;
	assign out_reductions = out_red_q;

endmodule
